/* design/csd_pkg.sv */
// Shared types and constants of the charset stream decoder.
// Used by the front, queue, back and top-level modules.
package csd_pkg;

    typedef enum logic [2:0] {
        MODE_UTF8    = 3'd0,
        MODE_LATIN1  = 3'd1,
        MODE_ASCII   = 3'd2,
        MODE_UTF16   = 3'd3,
        MODE_UTF16BE = 3'd4,
        MODE_UTF16LE = 3'd5
    } t_mode;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic REG_CHARSET_MODE = 1'b0;

    localparam logic [15:0] UNIT_REPL = 16'hFFFD;
    localparam logic [15:0] SUR_HIGH  = 16'hD800;
    localparam logic [15:0] SUR_LOW   = 16'hDC00;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam int CSD_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        two;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* design/csd_front.sv */
// Front end: accepts byte requests, runs the decoder state and forms unit bundles.
// Depends on csd_pkg.
module csd_front
    import csd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [2:0]  i_cfg_mode,
    output logic [2:0]  o_mode,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_bundle     o_bundle
);

    logic [2:0]  r_mode;
    logic [20:0] r_cp,      n_cp;
    logic [1:0]  r_left,    n_left;
    logic        r_first,   n_first;
    logic [7:0]  r_lead,    n_lead;
    logic [7:0]  r_pb,      n_pb;
    logic        r_pbv,     n_pbv;
    logic [15:0] r_hs,      n_hs;
    logic        r_hsv,     n_hsv;
    logic        r_bomc,    n_bomc;
    logic        r_le,      n_le;
    logic        r_ended,   n_ended;

    logic        accept;
    logic [1:0]  cnt;
    logic [15:0] u0, u1;
    logic        is_utf16;
    logic [1:0]  f_need;
    logic [20:0] f_cp;
    logic [7:0]  lo, hi;
    logic [20:0] cp_next, cp_off;
    logic [15:0] pair;
    logic        pair_high, pair_low;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_mode  = r_mode;
    assign is_utf16 = (r_mode == MODE_UTF16) || (r_mode == MODE_UTF16BE)
                   || (r_mode == MODE_UTF16LE);

    always_comb begin
        f_need = 2'd0;
        if (i_data_byte >= 8'hC2 && i_data_byte <= 8'hDF) begin
            f_need = 2'd1;
        end else if (i_data_byte >= 8'hE0 && i_data_byte <= 8'hEF) begin
            f_need = 2'd2;
        end else if (i_data_byte >= 8'hF0 && i_data_byte <= 8'hF4) begin
            f_need = 2'd3;
        end
        case (f_need)
            2'd1:    f_cp = {16'd0, i_data_byte[4:0]};
            2'd2:    f_cp = {17'd0, i_data_byte[3:0]};
            default: f_cp = {18'd0, i_data_byte[2:0]};
        endcase
        lo = 8'h80;
        hi = 8'hBF;
        if (r_first) begin
            case (r_lead)
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
            endcase
        end
        cp_next   = {r_cp[14:0], i_data_byte[5:0]};
        cp_off    = cp_next - SUPP_BASE;
        pair      = r_le ? {i_data_byte, r_pb} : {r_pb, i_data_byte};
        pair_high = (pair >= 16'hD800) && (pair <= 16'hDBFF);
        pair_low  = (pair >= 16'hDC00) && (pair <= 16'hDFFF);
    end

    always_comb begin
        n_cp    = r_cp;
        n_left  = r_left;
        n_first = r_first;
        n_lead  = r_lead;
        n_pb    = r_pb;
        n_pbv   = r_pbv;
        n_hs    = r_hs;
        n_hsv   = r_hsv;
        n_bomc  = r_bomc;
        n_le    = r_le;
        n_ended = r_ended;
        cnt     = 2'd0;
        u0      = UNIT_REPL;
        u1      = UNIT_REPL;
        if (!r_ended) begin
            if (i_op == OP_END) begin
                n_ended = 1'b1;
                if (is_utf16) begin
                    cnt   = {1'b0, r_hsv} + {1'b0, r_pbv};
                    n_hsv = 1'b0;
                    n_pbv = 1'b0;
                end else if (r_mode != MODE_LATIN1 && r_mode != MODE_ASCII) begin
                    cnt     = (r_left != 2'd0) ? 2'd1 : 2'd0;
                    n_left  = 2'd0;
                    n_first = 1'b0;
                end
            end else if (r_mode == MODE_LATIN1) begin
                cnt = 2'd1;
                u0  = {8'd0, i_data_byte};
            end else if (r_mode == MODE_ASCII) begin
                cnt = 2'd1;
                u0  = i_data_byte[7] ? UNIT_REPL : {8'd0, i_data_byte};
            end else if (is_utf16) begin
                if (!r_pbv) begin
                    n_pb  = i_data_byte;
                    n_pbv = 1'b1;
                end else begin
                    n_pbv = 1'b0;
                    n_pb  = 8'd0;
                    if (r_mode == MODE_UTF16 && !r_bomc && r_pb == 8'hFE
                        && i_data_byte == 8'hFF) begin
                        n_bomc = 1'b1;
                    end else if (r_mode == MODE_UTF16 && !r_bomc && r_pb == 8'hFF
                                 && i_data_byte == 8'hFE) begin
                        n_bomc = 1'b1;
                        n_le   = 1'b1;
                    end else begin
                        if (r_mode == MODE_UTF16) begin
                            n_bomc = 1'b1;
                        end
                        if (r_hsv && pair_low) begin
                            cnt   = 2'd2;
                            u0    = r_hs;
                            u1    = pair;
                            n_hsv = 1'b0;
                            n_hs  = 16'd0;
                        end else begin
                            n_hsv = 1'b0;
                            n_hs  = 16'd0;
                            if (pair_high) begin
                                n_hs  = pair;
                                n_hsv = 1'b1;
                                cnt   = r_hsv ? 2'd1 : 2'd0;
                            end else if (pair_low) begin
                                cnt = r_hsv ? 2'd2 : 2'd1;
                            end else if (r_hsv) begin
                                cnt = 2'd2;
                                u1  = pair;
                            end else begin
                                cnt = 2'd1;
                                u0  = pair;
                            end
                        end
                    end
                end
            end else begin
                if (r_left == 2'd0 || i_data_byte < lo || i_data_byte > hi) begin
                    // restart: emit a replacement if a sequence was open, then decode this byte afresh
                    if (r_left != 2'd0) begin
                        cnt = 2'd1;
                    end
                    n_left  = 2'd0;
                    n_first = 1'b0;
                    n_cp    = 21'd0;
                    if (!i_data_byte[7]) begin
                        if (cnt == 2'd0) begin
                            u0 = {8'd0, i_data_byte};
                        end else begin
                            u1 = {8'd0, i_data_byte};
                        end
                        cnt = cnt + 2'd1;
                    end else if (f_need == 2'd0) begin
                        cnt = cnt + 2'd1;
                    end else begin
                        n_left  = f_need;
                        n_first = 1'b1;
                        n_lead  = i_data_byte;
                        n_cp    = f_cp;
                    end
                end else begin
                    n_cp    = cp_next;
                    n_first = 1'b0;
                    n_left  = r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        n_cp = 21'd0;
                        if (cp_next >= SUPP_BASE) begin
                            cnt = 2'd2;
                            u0  = SUR_HIGH + {5'd0, cp_off[20:10]};
                            u1  = SUR_LOW + {6'd0, cp_off[9:0]};
                        end else begin
                            cnt = 2'd1;
                            u0  = cp_next[15:0];
                        end
                    end
                end
            end
        end
    end

    assign o_push         = accept && (cnt != 2'd0);
    assign o_bundle.two   = (cnt == 2'd2);
    assign o_bundle.unit0 = u0;
    assign o_bundle.unit1 = u1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_cp    <= 21'd0;
            r_left  <= 2'd0;
            r_first <= 1'b0;
            r_lead  <= 8'd0;
            r_pb    <= 8'd0;
            r_pbv   <= 1'b0;
            r_hs    <= 16'd0;
            r_hsv   <= 1'b0;
            r_bomc  <= 1'b0;
            r_ended <= 1'b0;
            r_le    <= i_rst_n && (i_cfg_mode == MODE_UTF16LE);
            r_mode  <= i_rst_n ? i_cfg_mode : MODE_UTF8;
        end else if (accept) begin
            r_cp    <= n_cp;
            r_left  <= n_left;
            r_first <= n_first;
            r_lead  <= n_lead;
            r_pb    <= n_pb;
            r_pbv   <= n_pbv;
            r_hs    <= n_hs;
            r_hsv   <= n_hsv;
            r_bomc  <= n_bomc;
            r_le    <= n_le;
            r_ended <= n_ended;
        end
    end

endmodule

/* design/csd_queue.sv */
// Short bundle queue between the decoder front and the output back end.
// Depends on csd_pkg.
module csd_queue
    import csd_pkg::*;
#(
    parameter int DEPTH = CSD_QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_bundle   i_bundle,
    input  logic      i_pop,
    output t_bundle   o_head,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");

endmodule

/* design/csd_back.sv */
// Back end: pops unit bundles and presents one code unit per cycle while i_ready is high, from output registers.
// Depends on csd_pkg.
module csd_back
    import csd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_last
);

    t_bundle r_bundle;
    logic    r_valid, n_valid;
    logic    r_idx,   n_idx;
    logic    fire;
    logic    done;

    assign fire  = r_valid && i_ready;
    assign done  = !r_valid || (fire && (!r_bundle.two || r_idx));
    assign o_pop = done && !i_q_status.empty;

    assign o_valid     = r_valid;
    assign o_code_unit = r_idx ? r_bundle.unit1 : r_bundle.unit0;
    assign o_last      = !r_bundle.two || r_idx;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (done) begin
            n_valid = !i_q_status.empty;
            n_idx   = 1'b0;
        end else if (fire) begin
            n_idx = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_head;
        end
    end

endmodule

/* design/charset_stream_to_utf16_decoder_core.sv */
// Top level of the charset stream decoder: register port, front, queue and back.
// Depends on csd_pkg, csd_front, csd_queue and csd_back.
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_ready      i_op, i_data_byte
//   output   out        o_valid / i_ready      o_code_unit, o_last
//   config   in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One request is taken per cycle while o_ready is high; the decoder state updates in
// the front in that cycle. Code units leave one per cycle while i_ready is high, so a
// request that yields a surrogate pair or a replacement plus a unit holds the output
// for both of its units; the bundle queue absorbs this. Reset is synchronous, no clearing
// pass. o_ready drops only while the bundle queue is full.
module charset_stream_to_utf16_decoder_core
    import csd_pkg::*;
#(
    parameter int QUEUE_DEPTH = CSD_QUEUE_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_last
);

    logic       cfg_wr;
    logic [2:0] mode;
    logic       push;
    logic       pop;
    t_bundle    push_bundle;
    t_bundle    head;
    t_q_status  q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHARSET_MODE);
    assign prdata = (paddr[2] == REG_CHARSET_MODE) ? {29'd0, mode} : 32'd0;

    csd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_mode  (pwdata[2:0]),
        .o_mode      (mode),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    csd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    csd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_unit (o_code_unit),
        .o_last      (o_last)
    );

endmodule

/* bench/charset_stream_to_utf16_decoder_core_tb.sv */
// Testbench of charset_stream_to_utf16_decoder_core: directed and random byte streams in every
// charset mode, checked unit by unit against a behavioral decoder kept in this file.
// Depends on csd_pkg and the decoder RTL only.
module charset_stream_to_utf16_decoder_core_tb;
    import csd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 750;
    localparam int SETTLE       = 4;

    typedef struct {
        logic [15:0] unit;
        logic        last;
    } t_unit_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = OP_DATA;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_last;

    charset_stream_to_utf16_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_unit (o_code_unit),
        .o_last      (o_last)
    );

    // decoder state as seen from outside
    logic [2:0]  cfg_mode;
    logic [20:0] cp_acc;
    logic [1:0]  cont_left;
    logic        first_cont;
    logic [7:0]  lead_b;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic [15:0] held_high;
    logic        high_valid;
    logic        order_checked;
    logic        little_end;
    logic        ended;

    logic [15:0] step_units[$];
    t_unit_rec   expected_units[$];
    logic [7:0]  stream_bytes[$];
    logic [7:0]  seq_bytes[$];

    int          cycle_count = 0;
    int          fail_count = 0;
    int          burst_left = 0;
    bit          free_run = 1'b0;
    int          rx_stretch = 0;
    int          rx_style = 0;
    logic [15:0] rx_pattern = '1;
    int          rx_idx = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void load_mode(input logic [2:0] m);
        cfg_mode      = m;
        cp_acc        = '0;
        cont_left     = '0;
        first_cont    = 1'b0;
        lead_b        = '0;
        held_byte     = '0;
        held_valid    = 1'b0;
        held_high     = '0;
        high_valid    = 1'b0;
        order_checked = 1'b0;
        little_end    = (m == MODE_UTF16LE);
        ended         = 1'b0;
    endfunction

    function automatic void put_unit(input logic [15:0] u);
        if (step_units.size() < 2) step_units.push_back(u);
    endfunction

    function automatic void put_code_point(input logic [20:0] cp);
        logic [20:0] off;
        if (cp >= SUPP_BASE) begin
            off = cp - SUPP_BASE;
            put_unit(SUR_HIGH + {6'd0, off[19:10]});
            put_unit(SUR_LOW + {6'd0, off[9:0]});
        end else begin
            put_unit(cp[15:0]);
        end
    endfunction

    function automatic void utf8_start(input logic [7:0] b);
        if (b < 8'h80) begin
            put_unit({8'h00, b});
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_left = 2'd1;
            cp_acc = {16'd0, b[4:0]};
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cont_left = 2'd2;
            cp_acc = {17'd0, b[3:0]};
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cont_left = 2'd3;
            cp_acc = {18'd0, b[2:0]};
        end else begin
            put_unit(UNIT_REPL);
            return;
        end
        first_cont = 1'b1;
        lead_b = b;
    endfunction

    function automatic void utf8_take(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (cont_left == 0) begin
            utf8_start(b);
            return;
        end
        if (first_cont) begin
            case (lead_b)
                8'hE0: lo = 8'hA0;
                8'hED: hi = 8'h9F;
                8'hF0: lo = 8'h90;
                8'hF4: hi = 8'h8F;
                default: ;
            endcase
        end
        if (b < lo || b > hi) begin
            cont_left = '0;
            first_cont = 1'b0;
            cp_acc = '0;
            put_unit(UNIT_REPL);
            utf8_start(b);
            return;
        end
        cp_acc = {cp_acc[14:0], b[5:0]};
        first_cont = 1'b0;
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) begin
            put_code_point(cp_acc);
            cp_acc = '0;
        end
    endfunction

    function automatic void utf16_unit(input logic [15:0] u);
        if (high_valid) begin
            high_valid = 1'b0;
            if (u >= SUR_LOW && u <= 16'hDFFF) begin
                put_unit(held_high);
                put_unit(u);
                held_high = '0;
                return;
            end
            held_high = '0;
            put_unit(UNIT_REPL);
        end
        if (u >= SUR_HIGH && u < SUR_LOW) begin
            held_high = u;
            high_valid = 1'b1;
        end else if (u >= SUR_LOW && u <= 16'hDFFF) begin
            put_unit(UNIT_REPL);
        end else begin
            put_unit(u);
        end
    endfunction

    function automatic void utf16_take(input logic [7:0] b);
        logic [7:0] lo_byte;
        if (!held_valid) begin
            held_byte = b;
            held_valid = 1'b1;
            return;
        end
        lo_byte = held_byte;
        held_valid = 1'b0;
        held_byte = '0;
        if (cfg_mode == MODE_UTF16 && !order_checked) begin
            order_checked = 1'b1;
            if (lo_byte == 8'hFE && b == 8'hFF) return;
            if (lo_byte == 8'hFF && b == 8'hFE) begin
                little_end = 1'b1;
                return;
            end
        end
        utf16_unit(little_end ? {b, lo_byte} : {lo_byte, b});
    endfunction

    function automatic void decode_request(input logic op, input logic [7:0] b);
        t_unit_rec r;
        step_units.delete();
        if (ended) return;
        if (op == OP_END) begin
            ended = 1'b1;
            if (cfg_mode >= MODE_UTF16 && cfg_mode <= MODE_UTF16LE) begin
                if (high_valid) put_unit(UNIT_REPL);
                if (held_valid) put_unit(UNIT_REPL);
                high_valid = 1'b0;
                held_valid = 1'b0;
            end else if (cfg_mode != MODE_LATIN1 && cfg_mode != MODE_ASCII) begin
                if (cont_left != 0) put_unit(UNIT_REPL);
                cont_left = '0;
                first_cont = 1'b0;
            end
        end else if (cfg_mode == MODE_LATIN1) begin
            put_unit({8'h00, b});
        end else if (cfg_mode == MODE_ASCII) begin
            put_unit(b[7] ? UNIT_REPL : {8'h00, b});
        end else if (cfg_mode >= MODE_UTF16 && cfg_mode <= MODE_UTF16LE) begin
            utf16_take(b);
        end else begin
            utf8_take(b);
        end
        foreach (step_units[i]) begin
            r.unit = step_units[i];
            r.last = (i == step_units.size() - 1);
            expected_units.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_unit_rec want;
        cycle_count++;
        if (!i_rst_n) begin
            load_mode(MODE_UTF8);
        end else begin
            if (psel && penable && pwrite && pready && paddr == {REG_CHARSET_MODE, 2'b00})
                load_mode(pwdata[2:0]);
            if (i_valid && o_ready) decode_request(i_op, i_data_byte);
            if (o_valid && i_ready) begin
                if (expected_units.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected unit %h last %b", o_code_unit, o_last);
                    fail_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (o_code_unit !== want.unit || o_last !== want.last) begin
                        if (fail_count < 10)
                            $display("unit mismatch: expected %h last %b, got %h last %b",
                                     want.unit, want.last, o_code_unit, o_last);
                        fail_count++;
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("charset_stream_to_utf16_decoder_core verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_stretch == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_stretch = $urandom_range(20, 120);
            rx_pattern = 16'($urandom) | 16'h0001;
        end
        rx_stretch--;
        rx_idx = (rx_idx + 1) % 16;
        case (rx_style)
            0: i_ready <= 1'b1;
            1: i_ready <= rx_pattern[rx_idx];
            default: i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_req(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = free_run ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_op <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i]) send_req(OP_DATA, stream_bytes[i]);
        stream_bytes.delete();
    endtask

    task automatic wait_drained(input int settle);
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [2:0] m);
        wait_drained(SETTLE);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CHARSET_MODE, 2'b00};
        pwdata <= {29'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [20:0] pick_code_point(input int cls);
        logic [20:0] c;
        case (cls)
            0: c = 21'($urandom_range(0, 'h7F));
            1: c = 21'($urandom_range('h80, 'h7FF));
            2: begin
                c = 21'($urandom_range('h800, 'hF7FF));
                if (c >= 21'hD800) c = c + 21'h800;
            end
            default: c = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return c;
    endfunction

    function automatic void encode_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            seq_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            seq_bytes.push_back({3'b110, cp[10:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            seq_bytes.push_back({4'b1110, cp[15:12]});
            seq_bytes.push_back({2'b10, cp[11:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            seq_bytes.push_back({5'b11110, cp[20:18]});
            seq_bytes.push_back({2'b10, cp[17:12]});
            seq_bytes.push_back({2'b10, cp[11:6]});
            seq_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void push_unit16(input logic [15:0] u, input bit le);
        if (le) begin
            stream_bytes.push_back(u[7:0]);
            stream_bytes.push_back(u[15:8]);
        end else begin
            stream_bytes.push_back(u[15:8]);
            stream_bytes.push_back(u[7:0]);
        end
    endfunction

    function automatic logic [15:0] random_bmp();
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 'hD7FF));
        return 16'($urandom_range('hE000, 'hFFFF));
    endfunction

    // mostly well-formed sequences, some cut short, some with a bad continuation, some noise
    task automatic build_utf8(input int n);
        int k;
        while (stream_bytes.size() < n) begin
            k = $urandom_range(0, 9);
            seq_bytes.delete();
            if (k == 9) begin
                seq_bytes.push_back(8'($urandom));
            end else begin
                encode_utf8(pick_code_point(k <= 6 ? $urandom_range(0, 3)
                                                   : $urandom_range(1, 3)));
                if (k == 7)
                    repeat ($urandom_range(1, seq_bytes.size() - 1)) void'(seq_bytes.pop_back());
                else if (k == 8)
                    seq_bytes[$urandom_range(1, seq_bytes.size() - 1)] = 8'($urandom);
            end
            foreach (seq_bytes[i]) stream_bytes.push_back(seq_bytes[i]);
        end
    endtask

    task automatic build_utf16(input logic [2:0] m, input int n);
        int k;
        bit le;
        le = (m == MODE_UTF16LE);
        if (m == MODE_UTF16) begin
            case ($urandom_range(0, 2))
                0: push_unit16(16'hFEFF, 1'b0);
                1: begin
                    push_unit16(16'hFFFE, 1'b0);
                    le = 1'b1;
                end
                default: ;
            endcase
        end
        while (stream_bytes.size() < n) begin
            k = $urandom_range(0, 9);
            if (k <= 4) begin
                push_unit16(random_bmp(), le);
            end else if (k <= 6) begin
                push_unit16(SUR_HIGH | 16'($urandom_range(0, 'h3FF)), le);
                push_unit16(SUR_LOW | 16'($urandom_range(0, 'h3FF)), le);
            end else if (k == 7) begin
                push_unit16(SUR_HIGH | 16'($urandom_range(0, 'h3FF)), le);
            end else if (k == 8) begin
                push_unit16(SUR_LOW | 16'($urandom_range(0, 'h3FF)), le);
            end else begin
                stream_bytes.push_back(8'($urandom));
            end
        end
    endtask

    // runs in the reset mode, no register write yet
    task automatic test_utf8_sequences();
        stream_bytes = '{8'h7F, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE0, 8'h80, 8'hFF, 8'hE2, 8'h82};
        send_stream();
        send_req(OP_END, 8'h00);
        send_req(OP_DATA, 8'h41);
        send_req(OP_END, 8'hFF);
    endtask

    task automatic test_single_byte_modes();
        start_phase(MODE_LATIN1);
        stream_bytes = '{8'hFF, 8'h00};
        send_stream();
        start_phase(MODE_ASCII);
        stream_bytes = '{8'h80, 8'h7F};
        send_stream();
        send_req(OP_END, 8'h00);
        start_phase(3'd7);
        stream_bytes = '{8'hC3, 8'hA9};
        send_stream();
        send_req(OP_END, 8'h00);
    endtask

    task automatic test_utf16_pairs();
        start_phase(MODE_UTF16);
        stream_bytes = '{8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h00, 8'hDE};
        send_stream();
        send_req(OP_END, 8'h00);
        start_phase(MODE_UTF16BE);
        stream_bytes = '{8'hDC, 8'h00, 8'hD8, 8'h00, 8'h00, 8'h41, 8'hD8, 8'h00, 8'hAB};
        send_stream();
        send_req(OP_END, 8'h00);
    endtask

    task automatic test_random_streams();
        int sent;
        int span;
        logic [2:0] m;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            m = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            start_phase(m);
            free_run = ($urandom_range(0, 3) == 0);
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(4, 40);
            if (m == MODE_LATIN1 || m == MODE_ASCII)
                repeat (span) stream_bytes.push_back(8'($urandom));
            else if (m >= MODE_UTF16 && m <= MODE_UTF16LE)
                build_utf16(m, span);
            else
                build_utf8(span);
            sent += stream_bytes.size();
            send_stream();
            if ($urandom_range(0, 7) != 0) begin
                send_req(OP_END, 8'($urandom));
                sent++;
                repeat ($urandom_range(0, 2)) send_req(1'($urandom), 8'($urandom));
            end
        end
        free_run = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_utf8_sequences();
        test_single_byte_modes();
        test_utf16_pairs();
        test_random_streams();
        wait_drained(8);
        if (fail_count == 0)
            $display("charset_stream_to_utf16_decoder_core verification clean");
        else
            $display("charset_stream_to_utf16_decoder_core verification failed");
        $finish;
    end

endmodule

/* sim.f */
design/csd_pkg.sv
design/csd_front.sv
design/csd_queue.sv
design/csd_back.sv
design/charset_stream_to_utf16_decoder_core.sv
bench/charset_stream_to_utf16_decoder_core_tb.sv
